>>> design/superfast_hash_bucket_core_assert.svh
// ----------------------------------------------------------------------------
// superfast_hash_bucket_core assertion macros
// concurrent check helpers shared by the hash bucket core
// ----------------------------------------------------------------------------
`ifndef SUPERFAST_HASH_BUCKET_CORE_ASSERT_SVH
`define SUPERFAST_HASH_BUCKET_CORE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define SFHB_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sfhb check failed");

// next-cycle implication, checked out of reset
`define SFHB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sfhb check failed");

`endif

>>> design/sfhb_pkg.sv
// ----------------------------------------------------------------------------
// sfhb_pkg
// shared types and constants of the hash bucket core
// ----------------------------------------------------------------------------
package sfhb_pkg;

  localparam int unsigned HashW   = 32;
  localparam int unsigned DivCntW = 5;

  localparam logic [HashW-1:0]   BucketCountReset = 32'd29;
  localparam logic [1:0]         MixLast          = 2'd2;
  localparam logic [DivCntW-1:0] DivLast          = 5'd31;

  typedef enum logic [2:0] {
    ST_ACCEPT,
    ST_TAIL,
    ST_MIX,
    ST_DIV,
    ST_OUT
  } ctrl_state_e;

  typedef struct packed {
    logic       accept;
    logic       tail;
    logic       mix;
    logic [1:0] mix_sel;
    logic       div_init;
    logic       div_step;
    logic       load_out;
  } cmd_t;

  typedef struct packed {
    logic div_last;
  } sts_t;

endpackage

>>> design/sfhb_in_if.sv
// ----------------------------------------------------------------------------
// sfhb_in_if
// byte request channel into the hash bucket core
// ----------------------------------------------------------------------------
interface sfhb_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic [15:0] message_length;
  logic        first_byte;
  logic        last_byte;

  modport source (
    output valid, data_byte, message_length, first_byte, last_byte,
    input  ready
  );

  modport sink (
    input  valid, data_byte, message_length, first_byte, last_byte,
    output ready
  );
endinterface

>>> design/sfhb_out_if.sv
// ----------------------------------------------------------------------------
// sfhb_out_if
// result request channel out of the hash bucket core
// ----------------------------------------------------------------------------
interface sfhb_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] hash_value;
  logic [31:0] bucket_index;

  modport source (
    output valid, hash_value, bucket_index,
    input  ready
  );

  modport sink (
    input  valid, hash_value, bucket_index,
    output ready
  );
endinterface

>>> design/sfhb_ctrl.sv
// ----------------------------------------------------------------------------
// sfhb_ctrl
// sequencer: byte intake, tail and avalanche steps, divide, result hand-off
// ----------------------------------------------------------------------------
module sfhb_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_last_i,
  input  logic          out_ready_i,
  input  sfhb_pkg::sts_t sts_i,
  output sfhb_pkg::cmd_t cmd_o,
  output logic          in_ready_o,
  output logic          out_valid_o
);
  import sfhb_pkg::*;

  ctrl_state_e state_q, state_d;
  logic [1:0]  mix_cnt_q, mix_cnt_d;
  logic        out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_ACCEPT;
      mix_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      mix_cnt_q   <= mix_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    mix_cnt_d   = mix_cnt_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    cmd_o.mix_sel = mix_cnt_q;
    in_ready_o  = 1'b0;
    case (state_q)
      ST_ACCEPT: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
        if (in_valid_i && in_last_i) begin
          state_d = ST_TAIL;
        end
      end
      ST_TAIL: begin
        cmd_o.tail = 1'b1;
        mix_cnt_d  = '0;
        state_d    = ST_MIX;
      end
      ST_MIX: begin
        cmd_o.mix = 1'b1;
        mix_cnt_d = mix_cnt_q + 2'd1;
        if (mix_cnt_q == MixLast) begin
          cmd_o.div_init = 1'b1;
          state_d        = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_ACCEPT;
        end
      end
      default: begin
        state_d = ST_ACCEPT;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

>>> design/sfhb_dpath.sv
// ----------------------------------------------------------------------------
// sfhb_dpath
// message state, group mixing, tail and avalanche, bit-serial remainder
// ----------------------------------------------------------------------------
module sfhb_dpath #(
  parameter int unsigned LENGTH_BITS = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [31:0]   cfg_wdata_i,
  input  logic [7:0]    data_byte_i,
  input  logic [15:0]   message_length_i,
  input  logic          first_byte_i,
  input  sfhb_pkg::cmd_t cmd_i,
  output sfhb_pkg::sts_t sts_o,
  output logic [31:0]   hash_value_o,
  output logic [31:0]   bucket_index_o
);
  import sfhb_pkg::*;

  localparam logic [HashW-1:0] LenMask = HashW'((64'd1 << LENGTH_BITS) - 64'd1);

  logic [HashW-1:0]   bucket_count_q;
  logic [HashW-1:0]   run_hash_q, run_hash_d;
  logic [23:0]        pend_q, pend_d;
  logic [1:0]         phase_q, phase_d;
  logic               empty_q, empty_d;

  logic [HashW-1:0]   work_q, work_d;
  logic [HashW-1:0]   rem_q, rem_d;
  logic [HashW-1:0]   dvd_q, dvd_d;
  logic [DivCntW-1:0] div_cnt_q, div_cnt_d;
  logic [HashW-1:0]   hash_out_q, bucket_out_q;

  // message intake
  logic [HashW-1:0] len_val, base_h, grp_a, grp_t, grp_b;
  logic [23:0]      base_p;
  logic [1:0]       base_ph;
  logic             base_e;
  logic [15:0]      grp_hi;

  always_comb begin
    len_val = {16'b0, message_length_i} & LenMask;
    base_h  = first_byte_i ? len_val : run_hash_q;
    base_p  = first_byte_i ? 24'd0 : pend_q;
    base_ph = first_byte_i ? 2'd0 : phase_q;
    base_e  = first_byte_i ? (len_val == '0) : empty_q;
    grp_hi  = {data_byte_i, base_p[23:16]};
    grp_a   = base_h + {16'b0, base_p[15:0]};
    grp_t   = ({16'b0, grp_hi} << 11) ^ grp_a;
    grp_b   = (grp_a << 16) ^ grp_t;

    run_hash_d = base_h;
    pend_d     = base_p;
    phase_d    = base_ph;
    empty_d    = base_e;
    if (!base_e) begin
      if (base_ph == 2'd3) begin
        run_hash_d = grp_b + (grp_b >> 11);
        pend_d     = '0;
        phase_d    = '0;
      end else begin
        pend_d  = base_p | (24'(data_byte_i) << {base_ph, 3'b000});
        phase_d = base_ph + 2'd1;
      end
    end
  end

  // tail rule and avalanche
  logic [HashW-1:0] tl_a, tl_b, tl_c, mx_a;
  logic [7:0]       b0, b1, b2;

  always_comb begin
    b0   = pend_q[7:0];
    b1   = pend_q[15:8];
    b2   = pend_q[23:16];
    tl_a = run_hash_q;
    tl_b = run_hash_q;
    tl_c = run_hash_q;
    case (phase_q)
      2'd3: begin
        tl_a = run_hash_q + {16'b0, b1, b0};
        tl_b = tl_a ^ (tl_a << 16);
        tl_b = tl_b ^ ({{24{b2[7]}}, b2} << 18);
        tl_c = tl_b + (tl_b >> 11);
      end
      2'd2: begin
        tl_a = run_hash_q + {16'b0, b1, b0};
        tl_b = tl_a ^ (tl_a << 11);
        tl_c = tl_b + (tl_b >> 17);
      end
      2'd1: begin
        tl_a = run_hash_q + {{24{b0[7]}}, b0};
        tl_b = tl_a ^ (tl_a << 10);
        tl_c = tl_b + (tl_b >> 1);
      end
      default: begin
        tl_c = run_hash_q;
      end
    endcase

    mx_a = work_q;
    case (cmd_i.mix_sel)
      2'd0: begin
        mx_a = work_q ^ (work_q << 3);
        mx_a = mx_a + (mx_a >> 5);
      end
      2'd1: begin
        mx_a = work_q ^ (work_q << 4);
        mx_a = mx_a + (mx_a >> 17);
      end
      2'd2: begin
        mx_a = work_q ^ (work_q << 25);
        mx_a = mx_a + (mx_a >> 6);
      end
      default: begin
        mx_a = work_q;
      end
    endcase

    work_d = work_q;
    if (cmd_i.tail) begin
      work_d = tl_c;
    end else if (cmd_i.mix) begin
      work_d = mx_a;
    end
  end

  // restoring remainder, one dividend bit per cycle
  logic [HashW:0] rem_sh;

  always_comb begin
    rem_sh    = {rem_q, dvd_q[HashW-1]};
    rem_d     = rem_q;
    dvd_d     = dvd_q;
    div_cnt_d = div_cnt_q;
    if (cmd_i.div_init) begin
      rem_d     = '0;
      dvd_d     = mx_a;
      div_cnt_d = '0;
    end else if (cmd_i.div_step) begin
      if (rem_sh >= {1'b0, bucket_count_q}) begin
        rem_d = HashW'(rem_sh - {1'b0, bucket_count_q});
      end else begin
        rem_d = rem_sh[HashW-1:0];
      end
      dvd_d     = dvd_q << 1;
      div_cnt_d = div_cnt_q + DivCntW'(1);
    end
  end

  assign sts_o.div_last = (div_cnt_q == DivLast);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bucket_count_q <= BucketCountReset;
      run_hash_q     <= '0;
      pend_q         <= '0;
      phase_q        <= '0;
      empty_q        <= 1'b0;
      div_cnt_q      <= '0;
    end else begin
      if (cfg_we_i) begin
        bucket_count_q <= cfg_wdata_i;
      end
      if (cmd_i.accept) begin
        run_hash_q <= run_hash_d;
        pend_q     <= pend_d;
        phase_q    <= phase_d;
        empty_q    <= empty_d;
      end else if (cmd_i.tail) begin
        run_hash_q <= '0;
        pend_q     <= '0;
        phase_q    <= '0;
        empty_q    <= 1'b0;
      end
      div_cnt_q <= div_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q <= work_d;
    rem_q  <= rem_d;
    dvd_q  <= dvd_d;
    if (cmd_i.load_out) begin
      hash_out_q   <= work_q;
      bucket_out_q <= rem_q;
    end
  end

  assign hash_value_o   = hash_out_q;
  assign bucket_index_o = bucket_out_q;

endmodule

>>> design/superfast_hash_bucket_core.sv
// ----------------------------------------------------------------------------
// superfast_hash_bucket_core
// 32-bit SuperFastHash of a byte stream reduced to a bucket index
// ----------------------------------------------------------------------------
// channel  dir  payload                                            handshake
// in_i     in   data_byte, message_length, first_byte, last_byte   valid/ready
// out_o    out  hash_value, bucket_index                           valid/ready
// cfg      in   cfg_wdata_i (bucket count)                         cfg_we_i
//
// one byte per cycle while a message streams in
// after a last byte in_i.ready stays low through the tail step, the three avalanche
// steps, the bit-serial remainder and the load of the output register
// the output register holds a result until taken; the next message may stream
// in meanwhile, but its result then waits with in_i.ready low until the taking
// asynchronous reset clears message state and sets bucket count to 29
// ----------------------------------------------------------------------------
module superfast_hash_bucket_core #(
  parameter int unsigned LENGTH_BITS = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [31:0]  cfg_wdata_i,
  sfhb_in_if.sink      in_i,
  sfhb_out_if.source   out_o
);
  import sfhb_pkg::*;

  cmd_t cmd;
  sts_t sts;

  sfhb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_last_i   (in_i.last_byte),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid)
  );

  sfhb_dpath #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .data_byte_i      (in_i.data_byte),
    .message_length_i (in_i.message_length),
    .first_byte_i     (in_i.first_byte),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .hash_value_o     (out_o.hash_value),
    .bucket_index_o   (out_o.bucket_index)
  );

`include "superfast_hash_bucket_core_assert.svh"

  // a last byte stops intake until the result is built
  `SFHB_ASSERT_NEXT(a_last_stalls_in, clk_i, rst_ni, in_i.valid && in_i.ready && in_i.last_byte, !in_i.ready)

  // a new result appears just as intake reopens
  `SFHB_ASSERT_NOW(a_result_reopens_in, clk_i, rst_ni, $rose(out_o.valid), in_i.ready)

  // zero hash leaves zero remainder
  `SFHB_ASSERT_NOW(a_zero_hash_bucket, clk_i, rst_ni, out_o.valid && out_o.hash_value == 32'd0, out_o.bucket_index == 32'd0)

endmodule
